// ----- sv/iis_pkg.sv -----
// iis_pkg: shared types and constants for the integer interval set.
// No dependencies.
package iis_pkg;

    localparam int unsigned KEY_W = 64;
    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_RESULT
    } iis_state_t;

    // command from the controller to every cell
    typedef struct packed {
        logic             classify;   // latch per-cell compare flags
        logic             merge_step; // fold next touched range into the head, close the gap
        logic             insert;     // open a slot and write the new range
        logic             absorb;     // widen the head range by the new range
        logic [KEY_W-1:0] lo;         // keyed, ordered low end
        logic [KEY_W-1:0] hi;         // keyed, ordered high end
    } iis_cmd_t;

    function automatic logic [KEY_W-1:0] to_key(input logic [KEY_W-1:0] bits);
        return bits ^ SIGN_FLIP;
    endfunction

endpackage

// ----- sv/iis_cell.sv -----
// iis_cell: one table entry of the interval set, with its compare logic.
// Depends on iis_pkg.
module iis_cell
    import iis_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  iis_cmd_t         cmd,
    input  logic [KEY_W-1:0] query_key,
    input  logic [KEY_W-1:0] left_lo,
    input  logic [KEY_W-1:0] left_hi,
    input  logic             left_occ,
    input  logic             left_below,   // tied high on the first cell
    input  logic             left_touched,
    input  logic [KEY_W-1:0] right_lo,
    input  logic [KEY_W-1:0] right_hi,
    input  logic             right_occ,
    input  logic             right_below,
    input  logic             right_above,
    output logic [KEY_W-1:0] lo_out,
    output logic [KEY_W-1:0] hi_out,
    output logic             occ_out,
    output logic             below,        // ends at least two below new low
    output logic             above,        // starts at least two above new high
    output logic             touched,      // overlaps or touches the new range
    output logic             hit           // query key inside this entry
);

    logic [KEY_W-1:0] lo_reg, lo_next;
    logic [KEY_W-1:0] hi_reg, hi_next;
    logic             occ_reg, occ_next;
    logic             below_reg, below_next;
    logic             above_reg, above_next;
    logic             head, slot;

    assign touched = occ_reg && !below_reg && !above_reg;
    // head: first touched entry; slot: where a range touching nothing goes
    assign head    = touched && !left_touched;
    assign slot    = !below_reg && left_below;

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        occ_next   = occ_reg;
        below_next = below_reg;
        above_next = above_reg;
        if (cmd.classify)
        begin
            below_next = occ_reg && (cmd.lo != '0) && (hi_reg < cmd.lo - 1'b1);
            above_next = occ_reg && (cmd.hi != '1) && (lo_reg > cmd.hi + 1'b1);
        end
        else if (cmd.merge_step)
        begin
            if (head)
                hi_next = right_hi;
            else if (!below_reg)
            begin
                lo_next    = right_lo;
                hi_next    = right_hi;
                occ_next   = right_occ;
                below_next = right_below;
                above_next = right_above;
            end
        end
        else if (cmd.insert)
        begin
            if (slot)
            begin
                lo_next  = cmd.lo;
                hi_next  = cmd.hi;
                occ_next = 1'b1;
            end
            else if (!below_reg)
            begin
                lo_next  = left_lo;
                hi_next  = left_hi;
                occ_next = left_occ;
            end
        end
        else if (cmd.absorb && head)
        begin
            if (cmd.lo < lo_reg)
                lo_next = cmd.lo;
            if (cmd.hi > hi_reg)
                hi_next = cmd.hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            below_reg <= 1'b0;
            above_reg <= 1'b0;
        end
        else
        begin
            occ_reg   <= occ_next;
            below_reg <= below_next;
            above_reg <= above_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo_out  = lo_reg;
    assign hi_out  = hi_reg;
    assign occ_out = occ_reg;
    assign below   = below_reg;
    assign above   = above_reg;
    assign hit     = occ_reg && (query_key >= lo_reg) && (query_key <= hi_reg);

endmodule

// ----- sv/iis_ctrl.sv -----
// iis_ctrl: item sequencer for the interval set (handshake and state machine).
// Depends on iis_pkg.
module iis_ctrl
    import iis_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic is_add,
    input  logic out_stall,
    input  logic more,          // two or more stored ranges still to fold together
    output logic in_stall,
    output logic out_valid,
    output logic do_classify,
    output logic do_query,
    output logic do_merge,
    output logic do_final
);

    iis_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = is_add ? ST_MERGE : ST_RESULT;
            ST_MERGE:  if (!more) state_next = ST_RESULT;
            ST_RESULT: if (!out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        out_valid   = (state_reg == ST_RESULT);
        do_classify = (state_reg == ST_IDLE) && in_valid && is_add;
        do_query    = (state_reg == ST_IDLE) && in_valid && !is_add;
        do_merge    = (state_reg == ST_MERGE) && more;
        do_final    = (state_reg == ST_MERGE) && !more;
    end

endmodule

// ----- sv/integer_interval_set.sv -----
// integer_interval_set: top level, a row of range cells plus the item sequencer.
// Depends on iis_pkg, iis_cell, iis_ctrl.
//
// Usage
//   Input channel: in_valid / in_stall with action, range_low, range_high,
//   query_value. Output channel: out_valid / out_stall with one result item
//   per input item describing the set after that item.
//   Each table entry is a cell holding one range. On an add all cells compare
//   against the new range at the accepting edge; then, step by step, the
//   first touched range takes the upper end of its right-hand neighbour while
//   the cells beyond it load from their right-hand neighbours, until at most
//   one touched range is left. A last step widens that range, or opens a slot
//   by shifting cells right from their left-hand neighbours.
//   A query goes straight to the result; an add runs its merge steps and the
//   last step first. One item is in flight at a time: no new item is taken
//   until the result of the last one has been taken by the receiver.
//   Reset empties the set; table contents are undefined until written.
//   While the receiver stalls, the result holds and no new item is taken.
module integer_interval_set
    import iis_pkg::*;
#(
    parameter int unsigned MAX_RANGES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [63:0] range_low,
    input  logic [63:0] range_high,
    input  logic [63:0] query_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_member,
    output logic        set_empty,
    output logic        single_range,
    output logic [63:0] set_minimum,
    output logic [63:0] set_maximum,
    output logic [6:0]  ranges_held,
    output logic        overflow
);

    localparam int unsigned CW = $clog2(MAX_RANGES + 1);

    logic             do_classify, do_query, do_merge, do_final;
    logic             more, any_touched, fits;
    iis_cmd_t         cmd;
    logic [KEY_W-1:0] lo_reg, hi_reg, lo_next, hi_next;
    logic [KEY_W-1:0] max_reg;
    logic [KEY_W-1:0] query_key;
    logic [CW-1:0]    count_reg, count_next;
    logic             member_reg, over_reg;

    // cell g sits at index g+1 of the chain; the ends are tied off
    logic [KEY_W-1:0]      c_lo [MAX_RANGES+2];
    logic [KEY_W-1:0]      c_hi [MAX_RANGES+2];
    logic [MAX_RANGES+1:0] c_occ, c_below;
    logic [MAX_RANGES+1:1] c_above;
    logic [MAX_RANGES:0]   c_touched;
    logic [MAX_RANGES-1:0] hit;

    iis_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .is_add      (!action),
        .out_stall   (out_stall),
        .more        (more),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .do_classify (do_classify),
        .do_query    (do_query),
        .do_merge    (do_merge),
        .do_final    (do_final)
    );

    // order the ends of the new range as keys
    always_comb
    begin
        lo_next = to_key(range_low);
        hi_next = to_key(range_high);
        if (lo_next > hi_next)
        begin
            lo_next = to_key(range_high);
            hi_next = to_key(range_low);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_classify)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign query_key = to_key(query_value);

    // touched entries are contiguous, so two adjacent ones mean more folding
    always_comb
    begin
        more        = 1'b0;
        any_touched = 1'b0;
        for (int i = 1; i <= MAX_RANGES; i++)
            any_touched = any_touched | c_touched[i];
        for (int i = 1; i < MAX_RANGES; i++)
            more = more | (c_touched[i] & c_touched[i+1]);
    end

    // a range touching nothing needs the last cell free
    assign fits = any_touched || !c_occ[MAX_RANGES];

    always_comb
    begin
        cmd.classify   = do_classify;
        cmd.merge_step = do_merge;
        cmd.insert     = do_final && !any_touched && fits;
        cmd.absorb     = do_final && any_touched;
        cmd.lo         = do_classify ? lo_next : lo_reg;
        cmd.hi         = do_classify ? hi_next : hi_reg;
    end

    assign c_lo[0]                = '0;
    assign c_hi[0]                = '0;
    assign c_lo[MAX_RANGES+1]     = '0;
    assign c_hi[MAX_RANGES+1]     = '0;
    assign c_occ[0]               = 1'b0;
    assign c_occ[MAX_RANGES+1]    = 1'b0;
    assign c_below[0]             = 1'b1;
    assign c_below[MAX_RANGES+1]  = 1'b0;
    assign c_above[MAX_RANGES+1]  = 1'b0;
    assign c_touched[0]           = 1'b0;

    generate
        for (genvar g = 0; g < MAX_RANGES; g++)
        begin : g_cell
            iis_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .cmd          (cmd),
                .query_key    (query_key),
                .left_lo      (c_lo[g]),
                .left_hi      (c_hi[g]),
                .left_occ     (c_occ[g]),
                .left_below   (c_below[g]),
                .left_touched (c_touched[g]),
                .right_lo     (c_lo[g+2]),
                .right_hi     (c_hi[g+2]),
                .right_occ    (c_occ[g+2]),
                .right_below  (c_below[g+2]),
                .right_above  (c_above[g+2]),
                .lo_out       (c_lo[g+1]),
                .hi_out       (c_hi[g+1]),
                .occ_out      (c_occ[g+1]),
                .below        (c_below[g+1]),
                .above        (c_above[g+1]),
                .touched      (c_touched[g+1]),
                .hit          (hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.merge_step)
            count_next = count_reg - CW'(1);
        else if (cmd.insert)
            count_next = count_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            max_reg    <= '0;
            member_reg <= 1'b0;
            over_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            // the set only grows, so the top end is tracked on its own
            if (cmd.insert || cmd.absorb)
            begin
                if ((count_reg == '0) || (hi_reg > max_reg))
                    max_reg <= hi_reg;
            end
            if (do_classify)
                member_reg <= 1'b0;
            else if (do_query)
                member_reg <= |hit;
            if (do_query || do_classify)
                over_reg <= 1'b0;
            else if (do_final)
                over_reg <= !fits;
        end
    end

    assign is_member    = member_reg;
    assign set_empty    = (count_reg == '0);
    assign single_range = (count_reg == CW'(1));
    assign set_minimum  = set_empty ? '0 : to_key(c_lo[1]);
    assign set_maximum  = set_empty ? '0 : to_key(max_reg);
    assign ranges_held  = 7'(count_reg);
    assign overflow     = over_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RANGES))
        else $error("stored count beyond capacity");
    a_no_member_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        do_classify |=> !member_reg)
        else $error("membership flag set on add");
    a_count_stable_query: assert property (@(posedge clk) disable iff (!rst_n)
        do_query |=> $stable(count_reg))
        else $error("query changed stored count");
    a_overflow_keeps_set: assert property (@(posedge clk) disable iff (!rst_n)
        (do_final && !fits) |=> $stable(count_reg))
        else $error("dropped add changed stored count");
`endif

endmodule
